// ===== hdl/sha256sh_pkg.sv =====
// sha256sh_pkg: constants and helper functions for the streaming sha-256 hasher
// holds the initial hash words, the 64 round constants and the sigma functions
// no dependencies
package sha256sh_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned HASH_N   = 8;
  localparam int unsigned ROUNDS   = 64;
  localparam int unsigned SCHED_N  = 16;
  localparam int unsigned FILL_W   = 6;
  localparam int unsigned ROUND_W  = 6;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned LEN_W    = 64;

  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [FILL_W-1:0] PAD_LIMIT = 6'd56;

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t HASH_INIT [HASH_N] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t big_sig0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sig1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sig0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sig1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// ===== hdl/sha256_stream_hasher_unit.sv =====
// sha256_stream_hasher_unit: streaming sha-256, one message byte per input transfer
// one shared round unit runs the 64 rounds of each block under a small sequencer
// depends on sha256sh_pkg
//
// channel | dir | tdata                  | tuser           | tlast
// in_     | in  | [7:0] data_byte        | [0] has_byte    | last
// out_    | out | [31:0] digest_word     | [2:0] word_index| last_word
//
// a byte transfer is taken while in_tready is high; a byte that fills the 64-byte
// block adds the 64 rounds in the shared round unit and one hash update
// a last transfer adds the pad bytes (9 to 72), one at a time, and compresses each
// padded block, then eight digest transfers, one per cycle when out_tready is high
// in_tready is low from the first cycle of that work until the eighth word is taken
// synchronous active-low reset returns to the initial hash words with nothing buffered
module sha256_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] has_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] word_index
  output logic        out_tlast
);
  import sha256sh_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_COMP = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [LEN_W-1:0]   cnt_r, cnt_nxt;
  logic               fin_r, fin_nxt;
  logic               mark_r, mark_nxt;
  logic               extra_r, extra_nxt;
  logic               done_r, done_nxt;
  logic [ROUND_W-1:0] rnd_r;
  logic [IDX_W-1:0]   oidx_r;

  word_t sched_r [SCHED_N];
  word_t hs_r [HASH_N];
  word_t wv_r [HASH_N];

  logic        in_fire, out_fire;
  logic        wr_en, is_len, full, start_comp;
  logic [7:0]  wr_byte;
  logic [2:0]  len_sel;
  logic [LEN_W-1:0] bit_len;
  word_t       t1, t2, w_new;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid & in_tready;
  assign out_tvalid = (state_r == S_OUT);
  assign out_fire   = out_tvalid & out_tready;
  assign out_tdata  = hs_r[oidx_r];
  assign out_tuser  = oidx_r;
  assign out_tlast  = (oidx_r == IDX_W'(HASH_N - 1));

  // length bytes go out most significant first at fill 56..63
  assign bit_len = {cnt_r[LEN_W-4:0], 3'b000};
  assign len_sel = ~fill_r[2:0];
  assign is_len  = mark_r & ~extra_r & (fill_r >= PAD_LIMIT);

  always_comb begin
    wr_en   = 1'b0;
    wr_byte = in_tdata;
    if (state_r == S_IDLE) begin
      wr_en = in_fire & in_tuser;
    end else if (state_r == S_PAD) begin
      wr_en = 1'b1;
      if (!mark_r) begin
        wr_byte = PAD_MARK;
      end else if (is_len) begin
        wr_byte = bit_len[{len_sel, 3'b000} +: 8];
      end else begin
        wr_byte = 8'h00;
      end
    end
  end

  assign full       = wr_en & (fill_r == {FILL_W{1'b1}});
  assign start_comp = full;

  // one round of the shared unit
  assign t1 = wv_r[7] + big_sig1(wv_r[4]) + ((wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]))
              + ROUND_K[rnd_r] + sched_r[0];
  assign t2 = big_sig0(wv_r[0])
              + ((wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]));
  assign w_new = sched_r[0] + small_sig0(sched_r[1]) + sched_r[9] + small_sig1(sched_r[14]);

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    cnt_nxt   = cnt_r;
    fin_nxt   = fin_r;
    mark_nxt  = mark_r;
    extra_nxt = extra_r;
    done_nxt  = done_r;
    if (wr_en) begin
      fill_nxt = fill_r + 1'b1;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_tuser) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          fin_nxt = in_tlast;
          if (start_comp) begin
            state_nxt = S_COMP;
          end else if (in_tlast) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (!mark_r) begin
          mark_nxt  = 1'b1;
          extra_nxt = (fill_r > (PAD_LIMIT - 1'b1));
        end
        if (full) begin
          extra_nxt = 1'b0;
          done_nxt  = is_len;
          state_nxt = S_COMP;
        end
      end
      S_COMP: begin
        if (rnd_r == ROUND_W'(ROUNDS - 1)) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (done_r) begin
          state_nxt = S_OUT;
        end else if (fin_r) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_fire && out_tlast) begin
          state_nxt = S_IDLE;
          cnt_nxt   = '0;
          fin_nxt   = 1'b0;
          mark_nxt  = 1'b0;
          done_nxt  = 1'b0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      cnt_r   <= '0;
      fin_r   <= 1'b0;
      mark_r  <= 1'b0;
      extra_r <= 1'b0;
      done_r  <= 1'b0;
      rnd_r   <= '0;
      oidx_r  <= '0;
      for (int i = 0; i < HASH_N; i++) begin
        hs_r[i] <= HASH_INIT[i];
      end
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      cnt_r   <= cnt_nxt;
      fin_r   <= fin_nxt;
      mark_r  <= mark_nxt;
      extra_r <= extra_nxt;
      done_r  <= done_nxt;
      if (state_r == S_COMP) begin
        rnd_r <= rnd_r + 1'b1;
      end else begin
        rnd_r <= '0;
      end
      if (state_r == S_UPD) begin
        for (int i = 0; i < HASH_N; i++) begin
          hs_r[i] <= hs_r[i] + wv_r[i];
        end
      end
      if (out_fire) begin
        oidx_r <= oidx_r + 1'b1;
        if (out_tlast) begin
          for (int i = 0; i < HASH_N; i++) begin
            hs_r[i] <= HASH_INIT[i];
          end
        end
      end
    end
  end

  // block bytes land big-endian in the schedule window, which then slides one word per round
  always_ff @(posedge clk) begin
    if (wr_en) begin
      sched_r[fill_r[FILL_W-1:2]][{~fill_r[1:0], 3'b000} +: 8] <= wr_byte;
    end else if (state_r == S_COMP) begin
      for (int i = 0; i < SCHED_N - 1; i++) begin
        sched_r[i] <= sched_r[i+1];
      end
      sched_r[SCHED_N-1] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (start_comp) begin
      for (int i = 0; i < HASH_N; i++) begin
        wv_r[i] <= hs_r[i];
      end
    end else if (state_r == S_COMP) begin
      wv_r[0] <= t1 + t2;
      wv_r[1] <= wv_r[0];
      wv_r[2] <= wv_r[1];
      wv_r[3] <= wv_r[2];
      wv_r[4] <= wv_r[3] + t1;
      wv_r[5] <= wv_r[4];
      wv_r[6] <= wv_r[5];
      wv_r[7] <= wv_r[6];
    end
  end

endmodule
